// ===== src/assert_macros.svh =====
// Assertion macros shared by the phase rotator RTL.
// Every macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// When ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sfr_pkg.sv =====
// Shared constants and types for the Bloch phase rotator.
// No dependencies; used by every module of the block but sfr_ram.
`default_nettype none

package sfr_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int PHASE_BITS_DEF  = 32;
  localparam int INDEX_BITS_DEF  = 10;
  localparam int TABLE_DEPTH_DEF = 1024;

  // Configuration registers are at most 32 bits wide; five of them.
  localparam int REG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Sine table entries are unsigned Q1.24; coefficients are signed Q2.24.
  localparam int COEF_FRAC = 24;
  localparam int ROM_W     = COEF_FRAC + 1;
  localparam int COEF_W    = COEF_FRAC + 2;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] s;
  } rot_t;

endpackage

`default_nettype wire

// ===== src/bloch_phase_field_rotator.sv =====
// Channel  Direction  Handshake             Word
// cfg      in         cfg_we, never stalls  cfg_index selects, cfg_data carries the value
// in       in         in_valid / in_ready   three grid indices, three complex samples
// out      out        out_valid / out_ready three rotated complex samples
//
// One word per cycle sustained while out_ready is high; an accepted word passes every stage below to out_valid.
// Stages: index products, phase sum, sine table read, lane multiplies, round/saturate merge.
// The quarter-wave table RAM (two read ports) supplies cos and sin for each word entering stage 3.
// After reset all TABLE_DEPTH+1 table entries are loaded with in_ready low; cfg writes work.
// When out_ready is low, earlier stages keep filling; in_ready drops once all are full.
// Top level of the Bloch phase rotator. Depends on sfr_pkg, sfr_coef, sfr_lane, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bloch_phase_field_rotator #(
  parameter int SAMPLE_BITS = sfr_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = sfr_pkg::PHASE_BITS_DEF,
  parameter int INDEX_BITS  = sfr_pkg::INDEX_BITS_DEF,
  parameter int TABLE_DEPTH = sfr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::REG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [INDEX_BITS-1:0]         in_index_x,
  input  logic [INDEX_BITS-1:0]         in_index_y,
  input  logic [INDEX_BITS-1:0]         in_index_z,
  input  logic signed [SAMPLE_BITS-1:0] in_comp0_re,
  input  logic signed [SAMPLE_BITS-1:0] in_comp0_im,
  input  logic signed [SAMPLE_BITS-1:0] in_comp1_re,
  input  logic signed [SAMPLE_BITS-1:0] in_comp1_im,
  input  logic signed [SAMPLE_BITS-1:0] in_comp2_re,
  input  logic signed [SAMPLE_BITS-1:0] in_comp2_im,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_out0_re,
  output logic signed [SAMPLE_BITS-1:0] out_out0_im,
  output logic signed [SAMPLE_BITS-1:0] out_out1_re,
  output logic signed [SAMPLE_BITS-1:0] out_out1_im,
  output logic signed [SAMPLE_BITS-1:0] out_out2_re,
  output logic signed [SAMPLE_BITS-1:0] out_out2_im
);

  import sfr_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_ENABLE = 3'd0,
    REG_STEP_X       = 3'd1,
    REG_STEP_Y       = 3'd2,
    REG_STEP_Z       = 3'd3,
    REG_PHASE_OFFSET = 3'd4
  } cfg_reg_t;

  localparam int LANES = 3;
  localparam int MW    = REG_W + INDEX_BITS;
  localparam int AW    = $clog2(TABLE_DEPTH + 1);
  localparam int NPW   = PHASE_BITS - 2 + AW;
  localparam logic [AW-1:0]  DEPTH_A  = AW'(TABLE_DEPTH);
  localparam logic [NPW-1:0] N_RND    = NPW'(1) << (PHASE_BITS - 3);
  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

  // Configuration registers.
  logic             phase_enable_r;
  logic [REG_W-1:0] step_x_r, step_y_r, step_z_r, phase_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_enable_r <= 1'b0;
      step_x_r       <= '0;
      step_y_r       <= '0;
      step_z_r       <= '0;
      phase_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_ENABLE: phase_enable_r <= cfg_data[0];
        REG_STEP_X:       step_x_r       <= cfg_data;
        REG_STEP_Y:       step_y_r       <= cfg_data;
        REG_STEP_Z:       step_z_r       <= cfg_data;
        REG_PHASE_OFFSET: phase_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline valid bits and the backward ready chain.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic fill_done;
  logic pipe_busy;

  assign rdy5     = !out_valid_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1 && fill_done;
  assign pipe_busy = v1_r || v2_r || v3_r || v4_r || out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid && fill_done;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) out_valid_r <= v4_r;
    end
  end

  // Stage 1: per-axis phase products.
  logic signed [SAMPLE_BITS-1:0] in_re [LANES];
  logic signed [SAMPLE_BITS-1:0] in_im [LANES];
  logic signed [SAMPLE_BITS-1:0] s1_re_r [LANES], s1_im_r [LANES];
  logic signed [SAMPLE_BITS-1:0] s2_re_r [LANES], s2_im_r [LANES];
  logic signed [SAMPLE_BITS-1:0] s3_re_r [LANES], s3_im_r [LANES];
  logic [MW-1:0]         mx, my, mz;
  logic [PHASE_BITS-1:0] px_r, py_r, pz_r;
  logic                  pass1_r, pass2_r, pass3_r;

  assign in_re[0] = in_comp0_re;
  assign in_im[0] = in_comp0_im;
  assign in_re[1] = in_comp1_re;
  assign in_im[1] = in_comp1_im;
  assign in_re[2] = in_comp2_re;
  assign in_im[2] = in_comp2_im;

  assign mx = MW'(step_x_r) * MW'(in_index_x);
  assign my = MW'(step_y_r) * MW'(in_index_y);
  assign mz = MW'(step_z_r) * MW'(in_index_z);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      px_r    <= PHASE_BITS'(mx);
      py_r    <= PHASE_BITS'(my);
      pz_r    <= PHASE_BITS'(mz);
      pass1_r <= !phase_enable_r;
      s1_re_r <= in_re;
      s1_im_r <= in_im;
    end
  end

  // Stage 2: total phase, modulo one turn.
  logic [PHASE_BITS-1:0] p2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p2_r    <= PHASE_BITS'(phase_offset_r) + px_r + py_r + pz_r;
      pass2_r <= pass1_r;
      s2_re_r <= s1_re_r;
      s2_im_r <= s1_im_r;
    end
  end

  // Stage 3: table addresses from the fraction within the quadrant; the RAM
  // output register holds this stage's table words.
  logic [PHASE_BITS-3:0] frac;
  logic [NPW-1:0]        nprod;
  logic [AW-1:0]         n_raw, n_idx, n_cmp;
  logic [1:0]            q3_r;
  logic [ROM_W-1:0]      tab_a, tab_b;

  assign frac  = p2_r[PHASE_BITS-3:0];
  assign nprod = NPW'(frac) * NPW'(TABLE_DEPTH) + N_RND;
  assign n_raw = nprod[NPW-1:PHASE_BITS-2];
  assign n_idx = (n_raw > DEPTH_A) ? DEPTH_A : n_raw;
  assign n_cmp = DEPTH_A - n_idx;

  sfr_coef #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (v2_r && rdy3),
    .rd_addr_a (n_idx),
    .rd_addr_b (n_cmp),
    .rd_data_a (tab_a),
    .rd_data_b (tab_b),
    .fill_done (fill_done)
  );

  always_ff @(posedge clk) begin
    if (rdy3) begin
      q3_r    <= p2_r[PHASE_BITS-1:PHASE_BITS-2];
      pass3_r <= pass2_r;
      s3_re_r <= s2_re_r;
      s3_im_r <= s2_im_r;
    end
  end

  // Quadrant folding; pass-through rotates by exactly one, which the rounding
  // returns unchanged.
  rot_t rot;

  always_comb begin
    if (pass3_r) begin
      rot.c = COEF_ONE;
      rot.s = '0;
    end else begin
      case (q3_r)
        2'd0: begin
          rot.c = COEF_W'(tab_b);
          rot.s = COEF_W'(tab_a);
        end
        2'd1: begin
          rot.c = -COEF_W'(tab_a);
          rot.s = COEF_W'(tab_b);
        end
        2'd2: begin
          rot.c = -COEF_W'(tab_b);
          rot.s = -COEF_W'(tab_a);
        end
        2'd3: begin
          rot.c = COEF_W'(tab_a);
          rot.s = -COEF_W'(tab_b);
        end
        default: begin
          rot.c = COEF_ONE;
          rot.s = '0;
        end
      endcase
    end
  end

  // Stage 4: lane multiplies. Stage 5: merged, rounded output word.
  logic signed [SAMPLE_BITS-1:0] lane_re [LANES], lane_im [LANES];
  logic signed [SAMPLE_BITS-1:0] out_re_r [LANES], out_im_r [LANES];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    sfr_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk    (clk),
      .en     (rdy4),
      .rot    (rot),
      .smp_re (s3_re_r[k]),
      .smp_im (s3_im_r[k]),
      .res_re (lane_re[k]),
      .res_im (lane_im[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_re_r <= lane_re;
      out_im_r <= lane_im;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_out0_re = out_re_r[0];
  assign out_out0_im = out_im_r[0];
  assign out_out1_re = out_re_r[1];
  assign out_out1_im = out_im_r[1];
  assign out_out2_re = out_re_r[2];
  assign out_out2_im = out_im_r[2];

  `ASSERT_IMPLY(a_idle_in_fill, !fill_done, !pipe_busy, "word in flight during table load")
  `ASSERT_NEXT(a_out_load, v4_r && rdy5, out_valid_r, "lane result not moved to output")
  `ASSERT_NEXT(a_stage3_hold, v3_r && !rdy4, v3_r, "table stage word dropped under stall")

endmodule

`default_nettype wire

// ===== src/sfr_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

// ===== src/sfr_coef.sv =====
// Quarter-wave sine table: contents built at elaboration, loaded into a RAM
// by a sweep after reset. Depends on sfr_pkg, sfr_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sfr_coef #(
  parameter int TABLE_DEPTH = sfr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               rd_en,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   rd_addr_a,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   rd_addr_b,
  output logic [sfr_pkg::ROM_W-1:0]          rd_data_a,
  output logic [sfr_pkg::ROM_W-1:0]          rd_data_b,
  output logic                               fill_done
);

  import sfr_pkg::*;

  localparam int DEPTH = TABLE_DEPTH + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH);

  logic [ROM_W-1:0] tab [DEPTH];
  logic [AW-1:0]    fill_cnt_r;
  logic [AW-1:0]    fill_cnt_nxt;
  logic             fill_done_r;
  logic             fill_done_nxt;

  // Each entry is sin(pi/2 * m / TABLE_DEPTH) from a Q30 Taylor series in Horner form.
  for (genvar m = 0; m < DEPTH; m++) begin : g_tab
    localparam logic [63:0] X   = (HALF_PI_Q30 * 64'(m)) / 64'(TABLE_DEPTH);
    localparam logic [63:0] X2  = (X * X) >> 30;
    localparam logic [63:0] H1  = Q30_ONE - ((X2 * Q30_ONE) >> 30) / 64'd156;
    localparam logic [63:0] H2  = Q30_ONE - ((X2 * H1) >> 30) / 64'd110;
    localparam logic [63:0] H3  = Q30_ONE - ((X2 * H2) >> 30) / 64'd72;
    localparam logic [63:0] H4  = Q30_ONE - ((X2 * H3) >> 30) / 64'd42;
    localparam logic [63:0] H5  = Q30_ONE - ((X2 * H4) >> 30) / 64'd20;
    localparam logic [63:0] H6  = Q30_ONE - ((X2 * H5) >> 30) / 64'd6;
    localparam logic [63:0] SV  = (X * H6) >> 30;
    localparam logic [63:0] TV  = (SV + 64'd32) >> 6;
    assign tab[m] = ROM_W'(TV);
  end

  always_comb begin
    fill_cnt_nxt  = fill_cnt_r;
    fill_done_nxt = fill_done_r;
    if (!fill_done_r) begin
      if (fill_cnt_r == LAST) begin
        fill_done_nxt = 1'b1;
      end else begin
        fill_cnt_nxt = fill_cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r  <= '0;
      fill_done_r <= 1'b0;
    end else begin
      fill_cnt_r  <= fill_cnt_nxt;
      fill_done_r <= fill_done_nxt;
    end
  end

  sfr_ram #(
    .WIDTH (ROM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (!fill_done_r),
    .waddr   (fill_cnt_r),
    .wdata   (tab[fill_cnt_r]),
    .re      (rd_en),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd_data_a),
    .rdata_b (rd_data_b)
  );

  assign fill_done = fill_done_r;

  `ASSERT_IMPLY(a_no_read_in_fill, !fill_done_r, !rd_en, "table read during load")
  `ASSERT_ALWAYS(a_fill_range, fill_cnt_r <= LAST, "load counter past table end")
  `ASSERT_NEXT(a_fill_sticky, fill_done_r, fill_done_r, "table load restarted")

endmodule

`default_nettype wire

// ===== src/sfr_lane.sv =====
// One rotation lane: complex multiply of a sample by (c, s), then rounding
// and saturation. Depends on sfr_pkg.
`default_nettype none

module sfr_lane #(
  parameter int SAMPLE_BITS = sfr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  sfr_pkg::rot_t                 rot,
  input  logic signed [SAMPLE_BITS-1:0] smp_re,
  input  logic signed [SAMPLE_BITS-1:0] smp_im,
  output logic signed [SAMPLE_BITS-1:0] res_re,
  output logic signed [SAMPLE_BITS-1:0] res_im
);

  import sfr_pkg::*;

  localparam int PW = SAMPLE_BITS + COEF_W;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] RND  = SW'(64'd1 << (COEF_FRAC - 1));
  localparam logic signed [SW-1:0] MAXV = SW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  logic signed [PW-1:0] re_x, im_x, c_x, s_x;
  logic signed [PW-1:0] p_rc_r, p_is_r, p_ic_r, p_rs_r;
  logic signed [SW-1:0] sum_re, sum_im;

  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [SW-1:0] v
  );
    logic signed [SW-1:0] t;
    t = v >>> COEF_FRAC;
    if (t > MAXV) begin
      t = MAXV;
    end else if (t < MINV) begin
      t = MINV;
    end
    return t[SAMPLE_BITS-1:0];
  endfunction

  assign re_x = PW'(smp_re);
  assign im_x = PW'(smp_im);
  assign c_x  = PW'(rot.c);
  assign s_x  = PW'(rot.s);

  always_ff @(posedge clk) begin
    if (en) begin
      p_rc_r <= re_x * c_x;
      p_is_r <= im_x * s_x;
      p_ic_r <= im_x * c_x;
      p_rs_r <= re_x * s_x;
    end
  end

  assign sum_re = SW'(p_rc_r) - SW'(p_is_r) + RND;
  assign sum_im = SW'(p_ic_r) + SW'(p_rs_r) + RND;
  assign res_re = round_sat(sum_re);
  assign res_im = round_sat(sum_im);

endmodule

`default_nettype wire
